@@ hdl/ist_pkg.sv @@
package ist_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_RSVD   = 2'd3
   } ist_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } ist_status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] range_start;
      logic [31:0] range_end;
   } ist_req_type;

   typedef struct packed {
      logic           covered;
      ist_status_type status;
   } ist_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_PROC,
      S_TAIL,
      S_DONE
   } ist_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic tail;
      logic finish;
   } ist_cmd_type;

   typedef struct packed {
      logic trivial;
      logic cnt_zero;
      logic last;
      logic stay;
      logic full;
      logic rsp_free;
   } ist_sts_type;

endpackage

@@ hdl/ist_ram.sv @@
module ist_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/ist_ctrl.sv @@
module ist_ctrl
   import ist_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ist_sts_type sts,
   output ist_cmd_type cmd
);

   ist_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (sts.trivial) state_in = S_DONE;
            else if (sts.cnt_zero) state_in = S_TAIL;
            else state_in = S_READ;
         end
         S_READ:  state_in = S_PROC;
         S_PROC: begin
            if (sts.full) state_in = S_DONE;
            else if (sts.stay) state_in = S_PROC;
            else if (sts.last) state_in = S_TAIL;
            else state_in = S_READ;
         end
         S_TAIL:  state_in = S_DONE;
         S_DONE:  if (sts.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_PROC:  cmd.step   = 1'b1;
         S_TAIL:  cmd.tail   = 1'b1;
         S_DONE:  cmd.finish = sts.rsp_free;
         default: cmd        = '0;
      endcase
   end

endmodule

@@ hdl/ist_dp.sv @@
module ist_dp
   import ist_pkg::*;
#(
   parameter int MAX_INTERVALS = 16,
   parameter int COORD_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  ist_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ist_rsp_type rsp_data,
   input  ist_cmd_type cmd,
   output ist_sts_type sts
);

   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int NW = $clog2(MAX_INTERVALS + 1);
   localparam int CB = COORD_BITS;

   logic [CB-1:0]  l_ff, r_ff, ml_ff, mr_ff;
   ist_op_type     op_ff;
   logic [NW-1:0]  idx_ff, n_ff, cnt_ff;
   logic           placed_ff, half_ff, cov_ff, bank_ff;
   ist_status_type status_ff;
   logic           rsp_valid_ff;
   ist_rsp_type    rsp_ff;

   logic [2*CB-1:0] rd0, rd1, rd, wr_data;
   logic [CB-1:0]   s, e, wr_s, wr_e;
   logic            wr_req, wr_en, adv, set_placed, set_half, clr_half, merge, hit, full;
   logic            trivial, commit;

   assign rd = bank_ff ? rd1 : rd0;
   assign s  = rd[2*CB-1:CB];
   assign e  = rd[CB-1:0];
   assign wr_data = {wr_s, wr_e};

   ist_ram #(.WIDTH(2*CB), .DEPTH(MAX_INTERVALS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (n_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd0)
   );

   ist_ram #(.WIDTH(2*CB), .DEPTH(MAX_INTERVALS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (n_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd1)
   );

   // per-entry decision
   always_comb begin
      wr_req     = 1'b0;
      wr_s       = s;
      wr_e       = e;
      adv        = 1'b0;
      set_placed = 1'b0;
      set_half   = 1'b0;
      clr_half   = 1'b0;
      merge      = 1'b0;
      hit        = 1'b0;
      if (cmd.step) begin
         case (op_ff)
            OP_ADD: begin
               if (e < l_ff) begin
                  wr_req = 1'b1;
                  adv    = 1'b1;
               end else if (s <= r_ff) begin
                  merge = 1'b1;
                  adv   = 1'b1;
               end else if (!placed_ff) begin
                  wr_req     = 1'b1;
                  wr_s       = ml_ff;
                  wr_e       = mr_ff;
                  set_placed = 1'b1;
               end else begin
                  wr_req = 1'b1;
                  adv    = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (half_ff) begin
                  wr_req   = 1'b1;
                  wr_s     = r_ff;
                  clr_half = 1'b1;
                  adv      = 1'b1;
               end else if (s < r_ff && e > l_ff) begin
                  if (s < l_ff) begin
                     wr_req = 1'b1;
                     wr_e   = l_ff;
                     if (e > r_ff) set_half = 1'b1;
                     else adv = 1'b1;
                  end else if (e > r_ff) begin
                     wr_req = 1'b1;
                     wr_s   = r_ff;
                     adv    = 1'b1;
                  end else begin
                     adv = 1'b1;
                  end
               end else begin
                  wr_req = 1'b1;
                  adv    = 1'b1;
               end
            end
            OP_QUERY: begin
               hit = (s <= l_ff) && (e >= r_ff);
               adv = 1'b1;
            end
            default: adv = 1'b1;
         endcase
      end else if (cmd.tail && op_ff == OP_ADD && !placed_ff) begin
         wr_req = 1'b1;
         wr_s   = ml_ff;
         wr_e   = mr_ff;
      end
   end

   assign full    = wr_req && (n_ff == NW'(MAX_INTERVALS));
   assign wr_en   = wr_req && !full;
   assign trivial = (op_ff == OP_RSVD) || (r_ff <= l_ff);
   assign commit  = cmd.finish && !trivial && status_ff == ST_OK
                    && (op_ff == OP_ADD || op_ff == OP_REMOVE);

   assign sts.trivial  = trivial;
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.last     = (idx_ff + NW'(1) == cnt_ff);
   assign sts.stay     = !adv;
   assign sts.full     = full;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= ist_op_type'(req_data.req_type);
         l_ff      <= CB'(req_data.range_start);
         r_ff      <= CB'(req_data.range_end);
         ml_ff     <= CB'(req_data.range_start);
         mr_ff     <= CB'(req_data.range_end);
         idx_ff    <= '0;
         n_ff      <= '0;
         placed_ff <= 1'b0;
         half_ff   <= 1'b0;
         cov_ff    <= 1'b0;
         status_ff <= ST_OK;
      end else if (cmd.step || cmd.tail) begin
         if (full) begin
            status_ff <= ST_FULL;
         end else begin
            if (wr_en) n_ff <= n_ff + NW'(1);
            if (adv) idx_ff <= idx_ff + NW'(1);
            if (set_placed) placed_ff <= 1'b1;
            if (set_half) half_ff <= 1'b1;
            if (clr_half) half_ff <= 1'b0;
            if (merge) begin
               if (s < ml_ff) ml_ff <= s;
               if (e > mr_ff) mr_ff <= e;
            end
            if (hit) cov_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (commit) begin
            cnt_ff  <= n_ff;
            bank_ff <= !bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (op_ff == OP_RSVD) begin
            rsp_ff.covered <= 1'b0;
            rsp_ff.status  <= ST_OK;
         end else if (r_ff <= l_ff) begin
            rsp_ff.covered <= 1'b0;
            rsp_ff.status  <= ST_EMPTY;
         end else begin
            rsp_ff.covered <= cov_ff && op_ff == OP_QUERY;
            rsp_ff.status  <= status_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_INTERVALS))
      else $error("stored count above table size");
   a_no_overflow_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> n_ff < NW'(MAX_INTERVALS))
      else $error("write beyond table end");
   a_reject_keeps_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && status_ff == ST_FULL) |=> ($stable(cnt_ff) && $stable(bank_ff)))
      else $error("rejected request changed the table");
`endif

endmodule

@@ hdl/interval_set_table.sv @@
// The walk over the table goes one entry at a time through the single registered
//   read port of the bank; an empty table or an empty range skips the walk.
// No new request is accepted until the previous one has finished its walk and
//   registered its response.
// Reset: synchronous, active high; the table is empty and no response pends.
// A new request is taken while a finished response still waits downstream.
module interval_set_table
   import ist_pkg::*;
#(
   parameter int MAX_INTERVALS = 16,
   parameter int COORD_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ist_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ist_rsp_type rsp_data
);

   // Commands from the sequencer, status back from the datapath.
   ist_cmd_type cmd;
   ist_sts_type sts;

   // Sequencer: accept, walk the table one entry at a time, then respond.
   ist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: ping-pong table banks; the new table is built in the idle
   // bank and swapped in only when the request completes without overflow.
   ist_dp #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .COORD_BITS    (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import ist_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int IDLE_LIMIT  = 4000;

   // Track the interval table and compare each response with the oldest pending one.
   class interval_scoreboard;
      logic [31:0] span_lo[$];
      logic [31:0] span_hi[$];
      ist_rsp_type pending_rsp[$];
      int          error_count;

      function new();
         error_count = 0;
      endfunction

      function ist_status_type apply_add(logic [31:0] lo, logic [31:0] hi);
         logic [31:0] merged_lo, merged_hi;
         logic [31:0] new_lo[$];
         logic [31:0] new_hi[$];
         bit          placed;
         merged_lo = lo;
         merged_hi = hi;
         placed    = 0;
         foreach (span_lo[i]) begin
            if (span_hi[i] >= lo && span_lo[i] <= hi) begin
               if (span_lo[i] < merged_lo) merged_lo = span_lo[i];
               if (span_hi[i] > merged_hi) merged_hi = span_hi[i];
            end
         end
         foreach (span_lo[i]) begin
            if (span_hi[i] >= lo && span_lo[i] <= hi) continue;
            if (!placed && span_lo[i] > merged_hi) begin
               new_lo.push_back(merged_lo);
               new_hi.push_back(merged_hi);
               placed = 1;
            end
            new_lo.push_back(span_lo[i]);
            new_hi.push_back(span_hi[i]);
         end
         if (!placed) begin
            new_lo.push_back(merged_lo);
            new_hi.push_back(merged_hi);
         end
         if (new_lo.size() > TABLE_DEPTH) return ST_FULL;
         span_lo = new_lo;
         span_hi = new_hi;
         return ST_OK;
      endfunction

      function ist_status_type apply_remove(logic [31:0] lo, logic [31:0] hi);
         logic [31:0] new_lo[$];
         logic [31:0] new_hi[$];
         foreach (span_lo[i]) begin
            if (span_lo[i] < hi && span_hi[i] > lo) begin
               if (span_lo[i] < lo) begin
                  new_lo.push_back(span_lo[i]);
                  new_hi.push_back(lo);
               end
               if (span_hi[i] > hi) begin
                  new_lo.push_back(hi);
                  new_hi.push_back(span_hi[i]);
               end
            end else begin
               new_lo.push_back(span_lo[i]);
               new_hi.push_back(span_hi[i]);
            end
         end
         if (new_lo.size() > TABLE_DEPTH) return ST_FULL;
         span_lo = new_lo;
         span_hi = new_hi;
         return ST_OK;
      endfunction

      function void note_request(ist_req_type req);
         ist_rsp_type rsp;
         rsp.covered = 1'b0;
         rsp.status  = ST_OK;
         if (req.req_type == OP_RSVD) begin
            rsp.status = ST_OK;
         end else if (req.range_end <= req.range_start) begin
            rsp.status = ST_EMPTY;
         end else if (req.req_type == OP_ADD) begin
            rsp.status = apply_add(req.range_start, req.range_end);
         end else if (req.req_type == OP_REMOVE) begin
            rsp.status = apply_remove(req.range_start, req.range_end);
         end else begin
            foreach (span_lo[i])
               if (span_lo[i] <= req.range_start && span_hi[i] >= req.range_end)
                  rsp.covered = 1'b1;
         end
         pending_rsp.push_back(rsp);
      endfunction

      task check_response(ist_rsp_type got);
         ist_rsp_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with nothing pending");
            return;
         end
         want = pending_rsp.pop_front();
         if (got.covered !== want.covered)
            report_mismatch($sformatf("covered got %b want %b", got.covered, want.covered));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      endtask

      task report_mismatch(string msg);
         error_count++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ist_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ist_rsp_type rsp_data;

   interval_scoreboard tracker;
   bit  quiet_phase;
   bit  stim_done;
   int  idle_cycles = 0;

   interval_set_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check responses at the rising edge; count cycles without any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Stall the response side in random bursts, none in the quiet phase.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // Present one request and hold it until accepted; note it on acceptance.
   task automatic send_request(ist_op_type op, logic [31:0] lo, logic [31:0] hi);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.req_type    <= op;
      req_data.range_start <= lo;
      req_data.range_end   <= hi;
      req_valid            <= 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.note_request(req_data);
      @(negedge clock);
   endtask

   // Pick coordinates mostly in a small window so intervals collide and touch.
   function automatic logic [31:0] pick_coord(int window);
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, window);
      endcase
   endfunction

   initial begin
      logic [31:0] lo, hi;
      int          roll;
      ist_op_type  op;
      tracker     = new();
      quiet_phase = 0;
      stim_done   = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, extremes, touching merge, split, overflow.
      send_request(OP_QUERY, 32'd0, 32'd1);
      send_request(OP_ADD, 32'd10, 32'd10);
      send_request(OP_REMOVE, 32'd20, 32'd5);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_RSVD, 32'd1, 32'd2);
      send_request(OP_ADD, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'd100, 32'd200);
      send_request(OP_QUERY, 32'd50, 32'd150);
      send_request(OP_ADD, 32'd100, 32'd150);
      send_request(OP_ADD, 32'd150, 32'd200);
      send_request(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++)
         send_request(OP_ADD, 32'(i * 10), 32'(i * 10 + 5));
      send_request(OP_REMOVE, 32'd1, 32'd2);
      send_request(OP_ADD, 32'd5, 32'd10);
      send_request(OP_QUERY, 32'd0, 32'd15);

      // Random: mostly adds and removes in a narrow window, with occasional wipes.
      for (int n = 0; n < 1550; n++) begin
         if (n == 1400) quiet_phase = 1;
         roll = $urandom_range(0, 99);
         if (roll < 40) op = OP_ADD;
         else if (roll < 70) op = OP_REMOVE;
         else if (roll < 97) op = OP_QUERY;
         else op = OP_RSVD;
         lo = pick_coord(400);
         if ($urandom_range(0, 9) == 0) hi = pick_coord(400);
         else hi = lo + $urandom_range(1, 30);
         if (op == OP_REMOVE && $urandom_range(0, 60) == 0) begin
            lo = 32'd0;
            hi = 32'hFFFF_FFFF;
         end
         send_request(op, lo, hi);
      end
      req_valid <= 1'b0;
      stim_done = 1;

      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (tracker.error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ interval_set_table.f @@
hdl/ist_pkg.sv
hdl/ist_ram.sv
hdl/ist_ctrl.sv
hdl/ist_dp.sv
hdl/interval_set_table.sv
test/tb_top.sv
